>>> design/fpa_pkg.sv
// Shared types and constants of the fixed-point ALU.
// Holds the operation codes, the queued item layout and the divider sizing.
// Depends on nothing; every other file refers to it by scoped names.
package fpa_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int DATA_W     = 32;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam int DIV_NW     = DATA_W + FRAC_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_NW + 1);

  typedef logic signed [DATA_W-1:0] word_t;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_TO_INT   = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_NONE     = 4'd15
  } op_t;

  // One classified item as it sits in the queue.
  typedef struct packed {
    op_t   op;
    word_t a;
    word_t b;
    logic  dz;       // divide with a zero divisor
    logic  use_div;  // divide that needs the iterative divider
  } item_t;

endpackage

>>> design/fpa_in_if.sv
// Input channel of the fixed-point ALU: valid/ready plus the operation and operands.
// Depends on fpa_pkg for the operand type.
interface fpa_in_if;
  logic              valid;
  logic              ready;
  logic [3:0]        kind;
  fpa_pkg::word_t    operand_a;
  fpa_pkg::word_t    operand_b;

  modport source (output valid, kind, operand_a, operand_b, input ready);
  modport sink   (input valid, kind, operand_a, operand_b, output ready);
endinterface

>>> design/fpa_out_if.sv
// Result channel of the fixed-point ALU: valid/ready plus the result and the flag.
// Depends on fpa_pkg for the result type.
interface fpa_out_if;
  logic              valid;
  logic              ready;
  fpa_pkg::word_t    result;
  logic              div_by_zero;

  modport source (output valid, result, div_by_zero, input ready);
  modport sink   (input valid, result, div_by_zero, output ready);
endinterface

>>> design/fpa_front.sv
// Front end of the fixed-point ALU: takes input transfers and classifies them.
// Depends on fpa_pkg and fpa_in_if; feeds fpa_queue.
module fpa_front (
  fpa_in_if.sink          in_ch,
  output logic            push_valid,
  input  logic            push_ready,
  output fpa_pkg::item_t  push_item
);

  fpa_pkg::op_t op;

  assign op = fpa_pkg::op_t'(in_ch.kind);

  always_comb begin
    push_item.op      = op;
    push_item.a       = in_ch.operand_a;
    push_item.b       = in_ch.operand_b;
    push_item.dz      = (op == fpa_pkg::OP_DIV) && (in_ch.operand_b == '0);
    push_item.use_div = (op == fpa_pkg::OP_DIV) && (in_ch.operand_b != '0);
  end

  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;

endmodule

>>> design/fpa_queue.sv
// Short register queue between the front and back ends of the fixed-point ALU.
// Depends on fpa_pkg for the item layout and depth.
module fpa_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  fpa_pkg::item_t  push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output fpa_pkg::item_t  pop_item
);

  fpa_pkg::item_t                 mem_r [fpa_pkg::QDEPTH];
  logic [fpa_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [fpa_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [fpa_pkg::QCNT_W-1:0]     count_r, count_nxt;
  logic                           do_push, do_pop;

  function automatic logic [fpa_pkg::QCNT_W-1:0] QCNT_INC(input logic v);
    QCNT_INC = {{(fpa_pkg::QCNT_W-1){1'b0}}, v};
  endfunction

  assign push_ready = (count_r != fpa_pkg::QCNT_W'(fpa_pkg::QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_INC(do_push) - QCNT_INC(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> design/fpa_div.sv
// Iterative restoring divider of the fixed-point ALU, one quotient bit per cycle.
// Divides |a| << FRAC_BITS by |b| and applies the sign; depends on fpa_pkg.
module fpa_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  fpa_pkg::word_t  a,
  input  fpa_pkg::word_t  b,
  input  logic            ack,
  output logic            busy,
  output logic            done,
  output fpa_pkg::word_t  quot
);

  logic [fpa_pkg::DIV_NW-1:0]     num_r;
  logic [fpa_pkg::DATA_W-1:0]     den_r;
  logic [fpa_pkg::DATA_W-1:0]     rem_r;
  logic                           neg_r;
  logic [fpa_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic                           busy_r, done_r;
  logic [fpa_pkg::DATA_W-1:0]     mag_a, mag_b;
  logic [fpa_pkg::DATA_W:0]       trial;
  logic                           qbit;
  logic [fpa_pkg::DATA_W-1:0]     q_low;

  assign mag_a = a[fpa_pkg::DATA_W-1] ? -a : a;
  assign mag_b = b[fpa_pkg::DATA_W-1] ? -b : b;
  assign trial = {rem_r, num_r[fpa_pkg::DIV_NW-1]};
  assign qbit  = (trial >= {1'b0, den_r});
  assign q_low = num_r[fpa_pkg::DATA_W-1:0];
  assign quot  = neg_r ? -q_low : q_low;
  assign busy  = busy_r;
  assign done  = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= fpa_pkg::DIV_CNT_W'(fpa_pkg::DIV_NW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == fpa_pkg::DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else if (ack) begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= fpa_pkg::DIV_NW'(mag_a) << fpa_pkg::FRAC_BITS;
      den_r <= mag_b;
      rem_r <= '0;
      neg_r <= a[fpa_pkg::DATA_W-1] ^ b[fpa_pkg::DATA_W-1];
    end else if (busy_r) begin
      rem_r <= qbit ? fpa_pkg::DATA_W'(trial - {1'b0, den_r})
                    : trial[fpa_pkg::DATA_W-1:0];
      num_r <= {num_r[fpa_pkg::DIV_NW-2:0], qbit};
    end
  end

endmodule

>>> design/fpa_back.sv
// Back end of the fixed-point ALU: operand stage with the multiplier, the divider
// and the output register. Depends on fpa_pkg, fpa_out_if and fpa_div.
module fpa_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  output logic            head_ready,
  input  fpa_pkg::item_t  head_item,
  fpa_out_if.source       out_ch
);

  logic                       s1_valid_r;
  fpa_pkg::item_t             s1_item_r;
  logic signed [63:0]         s1_prod_r;
  logic                       out_valid_r;
  fpa_pkg::word_t             out_result_r, out_result_nxt;
  logic                       out_dz_r;
  logic                       out_adv, s1_move, s1_load, s1_ready_ok;
  logic                       div_start, div_busy, div_done;
  fpa_pkg::word_t             div_quot;
  fpa_pkg::word_t             a, b;

  assign out_adv     = !out_valid_r || out_ch.ready;
  assign s1_ready_ok = !s1_item_r.use_div || div_done;
  assign s1_move     = s1_valid_r && s1_ready_ok && out_adv;
  assign head_ready  = !s1_valid_r || s1_move;
  assign s1_load     = head_valid && head_ready;
  assign div_start   = s1_load && head_item.use_div;

  fpa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .a     (head_item.a),
    .b     (head_item.b),
    .ack   (s1_move),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign a = s1_item_r.a;
  assign b = s1_item_r.b;

  always_comb begin
    unique case (s1_item_r.op)
      fpa_pkg::OP_ADD:      out_result_nxt = a + b;
      fpa_pkg::OP_SUB:      out_result_nxt = a - b;
      fpa_pkg::OP_MUL:      out_result_nxt = s1_prod_r[fpa_pkg::FRAC_BITS +: fpa_pkg::DATA_W];
      fpa_pkg::OP_DIV:      out_result_nxt = s1_item_r.dz ? '0 : div_quot;
      fpa_pkg::OP_GT:       out_result_nxt = {{(fpa_pkg::DATA_W-1){1'b0}}, a > b};
      fpa_pkg::OP_LT:       out_result_nxt = {{(fpa_pkg::DATA_W-1){1'b0}}, a < b};
      fpa_pkg::OP_GE:       out_result_nxt = {{(fpa_pkg::DATA_W-1){1'b0}}, a >= b};
      fpa_pkg::OP_LE:       out_result_nxt = {{(fpa_pkg::DATA_W-1){1'b0}}, a <= b};
      fpa_pkg::OP_EQ:       out_result_nxt = {{(fpa_pkg::DATA_W-1){1'b0}}, a == b};
      fpa_pkg::OP_NE:       out_result_nxt = {{(fpa_pkg::DATA_W-1){1'b0}}, a != b};
      fpa_pkg::OP_MIN:      out_result_nxt = (a < b) ? a : b;
      fpa_pkg::OP_MAX:      out_result_nxt = (a < b) ? b : a;
      fpa_pkg::OP_INC:      out_result_nxt = a + 1'b1;
      fpa_pkg::OP_TO_INT:   out_result_nxt = a >>> fpa_pkg::FRAC_BITS;
      fpa_pkg::OP_FROM_INT: out_result_nxt = a <<< fpa_pkg::FRAC_BITS;
      fpa_pkg::OP_NONE:     out_result_nxt = '0;
      default:              out_result_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (head_ready) begin
        s1_valid_r <= head_valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_move;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_item_r <= head_item;
      s1_prod_r <= head_item.a * head_item.b;
    end
    if (s1_move) begin
      out_result_r <= out_result_nxt;
      out_dz_r     <= s1_item_r.dz;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result      = out_result_r;
  assign out_ch.div_by_zero = out_dz_r;

`ifndef ASSERT_OFF
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_dz_r |-> out_result_r == '0)
    else $error("divide by zero result is not zero");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_item_r.use_div && !div_done |-> !s1_move)
    else $error("divide left operand stage before quotient was ready");
`endif

endmodule

>>> design/fixed_point_alu.sv
// Fixed-point ALU, signed 32-bit words with FRAC_BITS fraction bits.
// An input transfer reaches the result through the queue, the operand stage and
// the output register; a divide also waits in the operand stage for the divider.
// Throughput: one item per cycle unless the output stalls or a divide is running.
// Reset (synchronous, active low) empties the queue and drops every valid.
// Depends on fpa_pkg, both channel interfaces, fpa_front, fpa_queue and fpa_back.
module fixed_point_alu (
  input  logic       clk,
  input  logic       rst_n,
  fpa_in_if.sink     in_ch,
  fpa_out_if.source  out_ch
);

  // The front end decodes each transfer into an operation and flags a divide
  // by zero up front, so the back end never starts the divider for one.
  logic            push_valid, push_ready;
  fpa_pkg::item_t  push_item;

  // The queue decouples the two halves: input transfers keep landing while a
  // divide occupies the back end, until the queue fills.
  logic            pop_valid, pop_ready;
  fpa_pkg::item_t  pop_item;

  fpa_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  fpa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // The back end registers the operands together with the multiplier product,
  // then forms the result into an output register that releases on ready.
  fpa_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (pop_valid),
    .head_ready (pop_ready),
    .head_item  (pop_item),
    .out_ch     (out_ch)
  );

endmodule

>>> verif/tb_top.sv
// Testbench for the fixed-point ALU: a directed table followed by random operations.
// Every result transfer is checked against a typed-in answer or a predictor of the arithmetic.
// Depends on fpa_pkg, fpa_in_if, fpa_out_if and fixed_point_alu.
module tb_top;

  typedef struct {
    fpa_pkg::op_t   op;
    fpa_pkg::word_t a;
    fpa_pkg::word_t b;
  } alu_req_t;

  typedef struct {
    fpa_pkg::word_t value;
    logic           dz;
  } alu_res_t;

  // A row of the directed table; when known is set, want holds the typed-in answer.
  typedef struct {
    fpa_pkg::op_t   op;
    fpa_pkg::word_t a;
    fpa_pkg::word_t b;
    bit             known;
    alu_res_t       want;
  } table_row_t;

  localparam int NUM_RANDOM = 530;
  localparam int MAX_GAP    = 18;
  localparam int LONG_HOLD  = 300;

  logic clk;
  logic rst_n;

  fpa_in_if  in_ch();
  fpa_out_if out_ch();

  fixed_point_alu dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  alu_res_t   pending_results[$];
  table_row_t script[$];
  int         error_count;
  int         sent_count;
  int         recv_count;
  int         dz_count;
  bit         send_done;
  bit         hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

  // Compute what the ALU must return for one operation, with 64-bit multiply and divide.
  function automatic alu_res_t compute_alu(input alu_req_t req);
    alu_res_t           res;
    logic signed [63:0] wa;
    logic signed [63:0] wb;
    logic signed [63:0] wide;
    begin
      wa = req.a;
      wb = req.b;
      res.dz = 1'b0;
      res.value = '0;
      case (req.op)
        fpa_pkg::OP_ADD:      res.value = req.a + req.b;
        fpa_pkg::OP_SUB:      res.value = req.a - req.b;
        fpa_pkg::OP_MUL: begin
          wide = wa * wb;
          res.value = wide >>> fpa_pkg::FRAC_BITS;
        end
        fpa_pkg::OP_DIV: begin
          if (req.b == 0) begin
            res.dz = 1'b1;
          end else begin
            // SystemVerilog signed division already truncates toward zero.
            wide = (wa <<< fpa_pkg::FRAC_BITS) / wb;
            res.value = wide[31:0];
          end
        end
        fpa_pkg::OP_GT:       res.value = (req.a > req.b) ? 1 : 0;
        fpa_pkg::OP_LT:       res.value = (req.a < req.b) ? 1 : 0;
        fpa_pkg::OP_GE:       res.value = (req.a >= req.b) ? 1 : 0;
        fpa_pkg::OP_LE:       res.value = (req.a <= req.b) ? 1 : 0;
        fpa_pkg::OP_EQ:       res.value = (req.a == req.b) ? 1 : 0;
        fpa_pkg::OP_NE:       res.value = (req.a != req.b) ? 1 : 0;
        fpa_pkg::OP_MIN:      res.value = (req.a < req.b) ? req.a : req.b;
        fpa_pkg::OP_MAX:      res.value = (req.a < req.b) ? req.b : req.a;
        fpa_pkg::OP_INC:      res.value = req.a + 1;
        fpa_pkg::OP_TO_INT:   res.value = req.a >>> fpa_pkg::FRAC_BITS;
        fpa_pkg::OP_FROM_INT: res.value = req.a << fpa_pkg::FRAC_BITS;
        default:              res.value = '0;
      endcase
      return res;
    end
  endfunction

  function automatic void add_row(input fpa_pkg::op_t op, input fpa_pkg::word_t a,
                                  input fpa_pkg::word_t b, input bit known,
                                  input fpa_pkg::word_t value, input logic dz);
    table_row_t row;
    begin
      row.op = op;
      row.a = a;
      row.b = b;
      row.known = known;
      row.want.value = value;
      row.want.dz = dz;
      script.push_back(row);
    end
  endfunction

  // Operands are drawn half the time from interesting corners, so that overflow, sign
  // handling and small divisors come up often, and otherwise fully at random.
  function automatic fpa_pkg::word_t pick_operand();
    fpa_pkg::word_t v;
    begin
      case ($urandom_range(0, 9))
        0: v = 32'sh7fffffff;
        1: v = 32'sh80000000;
        2: v = $signed($urandom_range(0, 4)) - 2;
        3: v = $signed($urandom_range(0, 1023)) - 512;
        4: v = $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
        default: v = $urandom;
      endcase
      return v;
    end
  endfunction

  // The directed rows: every operation at least once, the extremes of both operands,
  // division by zero, the most negative dividend over minus one and the unused code.
  // Values that are obvious from the definition are typed in; others use the predictor.
  initial begin
    add_row(fpa_pkg::OP_ADD,      32'sh7fffffff, 32'sd1,        1, 32'sh80000000, 1'b0);
    add_row(fpa_pkg::OP_SUB,      32'sh80000000, 32'sd1,        1, 32'sh7fffffff, 1'b0);
    add_row(fpa_pkg::OP_MUL,      32'sd256,      32'sd256,      1, 32'sd256,      1'b0);
    add_row(fpa_pkg::OP_MUL,      32'sh80000000, 32'sh80000000, 0, '0,            1'b0);
    add_row(fpa_pkg::OP_MUL,      32'sh7fffffff, 32'sh80000000, 0, '0,            1'b0);
    add_row(fpa_pkg::OP_MUL,      -32'sd1,       32'sd1,        1, -32'sd1,       1'b0);
    add_row(fpa_pkg::OP_DIV,      32'sd1234,     32'sd0,        1, 32'sd0,        1'b1);
    add_row(fpa_pkg::OP_DIV,      32'sd0,        32'sd0,        1, 32'sd0,        1'b1);
    add_row(fpa_pkg::OP_DIV,      32'sh80000000, -32'sd1,       0, '0,            1'b0);
    add_row(fpa_pkg::OP_DIV,      32'sh7fffffff, 32'sd1,        0, '0,            1'b0);
    add_row(fpa_pkg::OP_DIV,      -32'sd768,     32'sd512,      0, '0,            1'b0);
    add_row(fpa_pkg::OP_GT,       32'sh7fffffff, 32'sh80000000, 1, 32'sd1,        1'b0);
    add_row(fpa_pkg::OP_LT,       32'sh7fffffff, 32'sh80000000, 1, 32'sd0,        1'b0);
    add_row(fpa_pkg::OP_GE,       32'sd5,        32'sd5,        1, 32'sd1,        1'b0);
    add_row(fpa_pkg::OP_LE,       32'sh80000000, 32'sh80000000, 1, 32'sd1,        1'b0);
    add_row(fpa_pkg::OP_EQ,       -32'sd1,       32'shffffffff, 1, 32'sd1,        1'b0);
    add_row(fpa_pkg::OP_NE,       32'sd0,        32'sd0,        1, 32'sd0,        1'b0);
    add_row(fpa_pkg::OP_MIN,      32'sh80000000, 32'sh7fffffff, 1, 32'sh80000000, 1'b0);
    add_row(fpa_pkg::OP_MAX,      32'sh80000000, 32'sh7fffffff, 1, 32'sh7fffffff, 1'b0);
    add_row(fpa_pkg::OP_INC,      32'sh7fffffff, 32'sd0,        1, 32'sh80000000, 1'b0);
    add_row(fpa_pkg::OP_TO_INT,   -32'sd1,       32'sd0,        1, -32'sd1,       1'b0);
    add_row(fpa_pkg::OP_TO_INT,   32'sh7fffffff, 32'sh80000000, 1, 32'sh007fffff, 1'b0);
    add_row(fpa_pkg::OP_FROM_INT, 32'sh00ffffff, 32'sd0,        1, 32'shffffff00, 1'b0);
    add_row(fpa_pkg::OP_NONE,     32'sh7fffffff, 32'sh80000000, 1, 32'sd0,        1'b0);
    add_row(fpa_pkg::OP_NONE,     -32'sd1,       -32'sd1,       1, 32'sd0,        1'b0);
  end

  // Sender: reset, then the directed table, then random operations, each preceded
  // by a random number of idle cycles, possibly none. Only a transfer dequeues an item.
  initial begin
    alu_req_t req;
    alu_res_t res;
    int       gap;
    int       total;
    int       idx;
    in_ch.valid     <= 1'b0;
    in_ch.kind      <= '0;
    in_ch.operand_a <= '0;
    in_ch.operand_b <= '0;
    rst_n           <= 1'b0;
    error_count = 0;
    sent_count = 0;
    send_done = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    total = script.size() + NUM_RANDOM;
    for (idx = 0; idx < total; idx++) begin
      if (idx < script.size()) begin
        req.op = script[idx].op;
        req.a  = script[idx].a;
        req.b  = script[idx].b;
        res = script[idx].known ? script[idx].want : compute_alu(req);
      end else begin
        req.op = fpa_pkg::op_t'($urandom_range(0, 15));
        req.a  = pick_operand();
        req.b  = pick_operand();
        res = compute_alu(req);
      end
      // Runs without any gaps are kept so that back-to-back traffic gets exercised.
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_GAP);
      if (idx > 60 && idx < 120) gap = 0;
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_ch.valid     <= 1'b1;
      in_ch.kind      <= req.op;
      in_ch.operand_a <= req.a;
      in_ch.operand_b <= req.b;
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      // The expectation is queued at the transfer edge, before any result for it can exist.
      pending_results.push_back(res);
      sent_count++;
    end
    in_ch.valid <= 1'b0;
    send_done = 1'b1;
  end

  // Receiver: random stall lengths per result, plus one long hold-off early in the
  // random part while the sender keeps pushing, so the internal queue fills up.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!hold_done && sent_count >= 40) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_GAP);
      if (sent_count > 150 && sent_count < 220) stall = 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // Checker: samples each result transfer at the clock edge and compares it with
  // the oldest expectation.
  initial begin
    alu_res_t want;
    recv_count = 0;
    dz_count = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        recv_count++;
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected: result=%0d", out_ch.result);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_ch.div_by_zero) dz_count++;
          if (out_ch.result !== want.value) begin
            $error("result: expected %0d, actual %0d", want.value, out_ch.result);
            error_count++;
          end
          if (out_ch.div_by_zero !== want.dz) begin
            $error("div_by_zero: expected %0b, actual %0b", want.dz, out_ch.div_by_zero);
            error_count++;
          end
        end
      end
    end
  end

  // End of run: wait for the sender and for every expected result, then let the
  // block's longest latency pass in case anything unexpected follows.
  initial begin
    int waited;
    wait (send_done);
    waited = 0;
    while (pending_results.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      error_count++;
    end
    $display("Covered %0d operations (%0d directed), %0d results, %0d divide-by-zero flags.",
             sent_count, script.size(), recv_count, dz_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/fpa_pkg.sv
design/fpa_in_if.sv
design/fpa_out_if.sv
design/fpa_front.sv
design/fpa_queue.sv
design/fpa_div.sv
design/fpa_back.sv
design/fixed_point_alu.sv
verif/tb_top.sv
